// File: hw/rtl/crt_timing_address_generator_top_assert.svh
// Assertion macros for the CRT timing address generator.
// Included by the top level; define NO_ASSERTIONS to drop them.
`ifndef CRT_TIMING_ADDRESS_GENERATOR_TOP_ASSERT_SVH
`define CRT_TIMING_ADDRESS_GENERATOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CTAG_ASSERT_IMPL(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define CTAG_ASSERT_NEXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define CTAG_ASSERT_IMPL(lbl, a, c, msg)
`define CTAG_ASSERT_NEXT(lbl, a, c, msg)
`endif
`endif

// File: hw/rtl/ctag_pkg.sv
// Package for the CRT timing address generator: modes, register addresses, flag bits, register and state types.
// No dependencies.
package ctag_pkg;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_SEL   = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    localparam logic [4:0] REG_HTOT   = 5'd0;
    localparam logic [4:0] REG_HDISP  = 5'd1;
    localparam logic [4:0] REG_HSPOS  = 5'd2;
    localparam logic [4:0] REG_SYNCW  = 5'd3;
    localparam logic [4:0] REG_VTOT   = 5'd4;
    localparam logic [4:0] REG_VADJ   = 5'd5;
    localparam logic [4:0] REG_VDISP  = 5'd6;
    localparam logic [4:0] REG_VSPOS  = 5'd7;
    localparam logic [4:0] REG_MODE   = 5'd8;
    localparam logic [4:0] REG_RPC    = 5'd9;
    localparam logic [4:0] REG_SSH    = 5'd12;
    localparam logic [4:0] REG_SSL    = 5'd13;
    localparam logic [4:0] REG_CURH   = 5'd14;
    localparam logic [4:0] REG_CURL   = 5'd15;
    localparam logic [4:0] REG_LPH    = 5'd16;
    localparam logic [4:0] REG_LPL    = 5'd17;

    // timing flag bit positions
    localparam int TF_SOF    = 0;
    localparam int TF_FIRST  = 1;
    localparam int TF_HS     = 2;
    localparam int TF_VS     = 3;
    localparam int TF_HADVS  = 4;
    localparam int TF_INADJ  = 5;
    localparam int TF_CHKADJ = 6;
    localparam int TF_EOADJ  = 7;
    localparam int TF_EOMAIN = 8;
    localparam int TF_EOFL   = 9;
    localparam int TF_DUMMY  = 10;
    localparam int TF_EVEN   = 11;

    localparam logic [11:0] TF_RESET = 12'h003;

    typedef struct packed {
        logic [7:0]  horiz_total;
        logic [7:0]  horiz_displayed;
        logic [7:0]  hsync_position;
        logic [3:0]  hsync_width;
        logic [3:0]  vsync_width;
        logic [6:0]  vert_total;
        logic [4:0]  vert_adjust;
        logic [6:0]  vert_displayed;
        logic [6:0]  vsync_position;
        logic [1:0]  interlace_mode;
        logic [1:0]  enable_skew;
        logic [4:0]  rows_per_char;
        logic [13:0] screen_start;
        logic [13:0] cursor_address;
    } regs_t;

    typedef struct packed {
        logic [7:0]  column_count;
        logic [3:0]  hsync_count;
        logic [4:0]  scanline_count;
        logic [6:0]  row_count;
        logic [3:0]  vsync_count;
        logic [4:0]  adjust_count;
        logic [13:0] memory_address;
        logic [13:0] row_start;
        logic [13:0] next_row_start;
        logic [11:0] timing_flags;
        logic        frame_parity;
        logic [1:0]  border_flags;
    } cnt_t;

    // wrap subtrahends picked by the external latch
    function automatic logic [15:0] wrap_sub(input logic [1:0] sel);
        logic [15:0] r;
        case (sel)
            2'd0:    r = 16'h4000;
            2'd1:    r = 16'h2000;
            2'd2:    r = 16'h5000;
            default: r = 16'h2800;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/crt_timing_address_generator_top.sv
// CRT timing address generator: one transfer in, one transfer out.
// Pipeline: input register, then result register.
// Throughput: one item per cycle; a skid-free pipeline that stalls as a whole
// when the result register is full and not taken.
// Reset (rst_n, async): timing registers and counters cleared, start-of-frame
// and first-raster flags set, pipeline empty.
module crt_timing_address_generator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data, [9:8] wrap_select, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [15:0] dram_address, [16] hsync, [17] vsync,
                                   // [18] display_enable, [23:19] raster_row,
                                   // [31:24] read_data
    ,output logic       m_tuser    // [0] read_valid
);
    import ctag_pkg::*;

    logic        in_v_reg;
    logic [1:0]  mode_reg;
    logic [7:0]  data_reg;
    logic [1:0]  wsel_reg;
    logic        out_v_reg;
    logic [31:0] out_reg;
    logic        rv_reg;
    regs_t       regs_reg, regs_next;
    cnt_t        cnt_reg, cnt_next, tick_nxt;
    logic [4:0]  sel_reg, sel_next;
    logic [15:0] tick_addr;
    logic        adv;
    logic [7:0]  rd;
    logic        rv;
    logic [15:0] addr;

    // the whole pipe moves when the result slot is free or being taken
    assign adv      = !out_v_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = rv_reg;

    ctag_tick u_tick (
        .regs        (regs_reg),
        .cur         (cnt_reg),
        .wrap_select (wsel_reg),
        .nxt         (tick_nxt),
        .dram_address(tick_addr)
    );

    always_comb
    begin
        regs_next = regs_reg;
        cnt_next  = cnt_reg;
        sel_next  = sel_reg;
        rd = 8'd0;
        rv = 1'b0;
        addr = 16'd0;
        unique case (mode_t'(mode_reg))
            MODE_TICK:
            begin
                cnt_next = tick_nxt;
                addr = tick_addr;
            end
            MODE_SEL: sel_next = data_reg[4:0];
            MODE_WRITE:
            begin
                case (sel_reg)
                    REG_HTOT:  regs_next.horiz_total = data_reg;
                    REG_HDISP: regs_next.horiz_displayed = data_reg;
                    REG_HSPOS: regs_next.hsync_position = data_reg;
                    REG_SYNCW:
                    begin
                        regs_next.vsync_width = data_reg[7:4];
                        if (data_reg[3:0] != 4'd0) regs_next.hsync_width = data_reg[3:0];
                    end
                    REG_VTOT:  regs_next.vert_total = data_reg[6:0];
                    REG_VADJ:  regs_next.vert_adjust = data_reg[4:0];
                    REG_VDISP: regs_next.vert_displayed = data_reg[6:0];
                    REG_VSPOS: regs_next.vsync_position = data_reg[6:0];
                    REG_MODE:
                    begin
                        regs_next.interlace_mode = data_reg[1:0];
                        if (data_reg[5:4] != 2'd3) regs_next.enable_skew = data_reg[5:4];
                    end
                    REG_RPC:   regs_next.rows_per_char = data_reg[4:0];
                    REG_SSH:   regs_next.screen_start[13:8] = data_reg[5:0];
                    REG_SSL:   regs_next.screen_start[7:0] = data_reg;
                    REG_CURH:  regs_next.cursor_address[13:8] = data_reg[5:0];
                    REG_CURL:  regs_next.cursor_address[7:0] = data_reg;
                    default: ;
                endcase
            end
            MODE_READ:
            begin
                case (sel_reg)
                    REG_SSH:  begin rv = 1'b1; rd = {2'b00, regs_reg.screen_start[13:8]}; end
                    REG_SSL:  begin rv = 1'b1; rd = regs_reg.screen_start[7:0]; end
                    REG_CURH: begin rv = 1'b1; rd = {2'b00, regs_reg.cursor_address[13:8]}; end
                    REG_CURL: begin rv = 1'b1; rd = regs_reg.cursor_address[7:0]; end
                    REG_LPH, REG_LPL: rv = 1'b1;   // light pen never latched
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            regs_reg  <= '0;
            sel_reg   <= '0;
            cnt_reg   <= '{timing_flags: TF_RESET, default: '0};
        end
        else if (adv)
        begin
            in_v_reg  <= s_tvalid;
            out_v_reg <= in_v_reg;
            if (in_v_reg)
            begin
                regs_reg <= regs_next;
                cnt_reg  <= cnt_next;
                sel_reg  <= sel_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode_reg <= s_tuser;
            data_reg <= s_tdata[7:0];
            wsel_reg <= s_tdata[9:8];
            out_reg  <= {rd, cnt_next.scanline_count,
                         cnt_next.border_flags[1] & cnt_next.border_flags[0],
                         cnt_next.timing_flags[TF_VS], cnt_next.timing_flags[TF_HS], addr};
            rv_reg   <= rv;
        end
    end

`include "crt_timing_address_generator_top_assert.svh"

    `CTAG_ASSERT_NEXT(a_out_follows_in, adv && in_v_reg, m_tvalid, "result lost")
    `CTAG_ASSERT_IMPL(a_rd_only_read, m_tvalid && !m_tuser, m_tdata[31:24] == 8'd0, "stray read")
    `CTAG_ASSERT_IMPL(a_ready_free, !m_tvalid, s_tready, "stall with empty output")

endmodule

// File: hw/rtl/ctag_tick.sv
// Next-state logic of the timing counters, and the DRAM address, for one character tick.
// Depends on ctag_pkg.
module ctag_tick (
    input  ctag_pkg::regs_t     regs,
    input  ctag_pkg::cnt_t      cur,
    input  logic [1:0]          wrap_select,
    output ctag_pkg::cnt_t      nxt,
    output logic [15:0]         dram_address
);
    import ctag_pkg::*;

    always_comb
    begin
        cnt_t c;
        logic half, trig, ending, starting, r6, r7, r9, eof;
        logic [8:0] hd_skew, ht_skew;
        logic [15:0] a;
        c = cur;
        ending = 1'b0;
        starting = 1'b0;
        r9 = 1'b0;
        eof = 1'b0;
        hd_skew = {1'b0, regs.horiz_displayed} + {7'd0, regs.enable_skew};
        ht_skew = {1'b0, regs.horiz_total} + {7'd0, regs.enable_skew};

        if (c.timing_flags[TF_SOF])
        begin
            c.memory_address = regs.screen_start;
            c.row_start = regs.screen_start;
            c.timing_flags[TF_SOF] = 1'b0;
        end
        if (c.timing_flags[TF_HS])
        begin
            c.hsync_count = c.hsync_count + 4'd1;
            if (c.hsync_count == regs.hsync_width) c.timing_flags[TF_HS] = 1'b0;
        end
        if (c.column_count == regs.horiz_displayed) c.next_row_start = c.memory_address;
        if ({1'b0, c.column_count} == hd_skew || {1'b0, c.column_count} == ht_skew)
            c.border_flags[0] = 1'b0;
        if (c.column_count == regs.hsync_position && !c.timing_flags[TF_HS])
        begin
            c.timing_flags[TF_HS] = 1'b1;
            c.hsync_count = 4'd0;
        end
        half = (c.column_count == {1'b0, regs.horiz_total[7:1]});
        trig = !regs.interlace_mode[0] || !c.timing_flags[TF_EVEN] || half;
        if (c.timing_flags[TF_VS] && c.vsync_count == regs.vsync_width && trig)
        begin
            ending = 1'b1;
            c.timing_flags[TF_VS] = 1'b0;
        end
        if (c.row_count == regs.vsync_position && !c.timing_flags[TF_VS]
            && !c.timing_flags[TF_HADVS] && trig)
        begin
            starting = 1'b1;
            c.timing_flags[TF_VS] = 1'b1;
        end
        if (starting && !ending)
        begin
            c.timing_flags[TF_HADVS] = 1'b1;
            c.vsync_count = 4'd0;
        end
        c.memory_address = c.memory_address + 14'd1;
        if (c.timing_flags[TF_CHKADJ])
        begin
            c.timing_flags[TF_CHKADJ] = 1'b0;
            if (c.timing_flags[TF_EOMAIN])
            begin
                if (c.adjust_count == regs.vert_adjust) c.timing_flags[TF_EOADJ] = 1'b1;
                c.adjust_count = c.adjust_count + 5'd1;
            end
        end
        if (c.column_count == 8'd1)
        begin
            if (c.row_count == regs.vert_total && c.scanline_count == regs.rows_per_char)
            begin
                c.timing_flags[TF_EOMAIN] = 1'b1;
                c.adjust_count = 5'd0;
            end
            c.timing_flags[TF_CHKADJ] = 1'b1;
        end
        if (c.column_count == regs.horiz_total)
        begin
            // end of scanline
            c.timing_flags[TF_FIRST] = 1'b0;
            c.vsync_count = c.vsync_count + 4'd1;
            r9 = (c.scanline_count == regs.rows_per_char);
            if (r9) c.row_start = c.next_row_start;
            if (regs.interlace_mode == 2'd3)
                c.scanline_count = (c.scanline_count + 5'd2) & 5'h1e;
            else
                c.scanline_count = c.scanline_count + 5'd1;
            if (!c.timing_flags[TF_INADJ] && r9)
            begin
                c.row_count = c.row_count + 7'd1;
                c.scanline_count = 5'd0;
                c.timing_flags[TF_HADVS] = 1'b0;
            end
            if (c.timing_flags[TF_EOMAIN] && !c.timing_flags[TF_EOADJ])
                c.timing_flags[TF_INADJ] = 1'b1;
            eof = c.timing_flags[TF_EOFL];
            if (c.timing_flags[TF_EOADJ])
            begin
                c.timing_flags[TF_INADJ] = 1'b0;
                if (regs.interlace_mode[0] && c.timing_flags[TF_EVEN])
                begin
                    c.timing_flags[TF_DUMMY] = 1'b1;
                    c.timing_flags[TF_EOFL] = 1'b1;
                end
                else eof = 1'b1;
            end
            if (eof)
            begin
                c.timing_flags[TF_EOMAIN] = 1'b0;
                c.timing_flags[TF_EOADJ] = 1'b0;
                c.timing_flags[TF_EOFL] = 1'b0;
                c.timing_flags[TF_DUMMY] = 1'b0;
                c.timing_flags[TF_SOF] = 1'b1;
                c.scanline_count = 5'd0;
                c.timing_flags[TF_HADVS] = 1'b0;
                c.row_count = 7'd0;
                c.timing_flags[TF_FIRST] = 1'b1;
                c.next_row_start = regs.screen_start;
                c.row_start = regs.screen_start;
                c.border_flags[1] = 1'b1;
                if (!c.timing_flags[TF_VS]) c.timing_flags[TF_EVEN] = 1'b0;
            end
            c.memory_address = c.row_start;
            c.column_count = 8'd0;
            c.border_flags[0] = 1'b1;
        end
        else
        begin
            c.column_count = c.column_count + 8'd1;
        end
        r6 = (c.row_count == regs.vert_displayed);
        if (r6 && !c.timing_flags[TF_FIRST] && c.border_flags[1])
        begin
            c.border_flags[1] = 1'b0;
            c.frame_parity = ~c.frame_parity;
        end
        r7 = (c.row_count == regs.vsync_position);
        if (r6 || r7) c.timing_flags[TF_EVEN] = c.frame_parity;

        // address mapping
        if (c.memory_address[13])
            a = {1'b0, c.memory_address[11], 4'b1111, c.memory_address[9:0]};
        else
        begin
            a = {c.memory_address[12:0], c.scanline_count[2:0]};
            if (c.memory_address[12]) a = a - wrap_sub(wrap_select);
        end
        nxt = c;
        dram_address = a;
    end
endmodule
